@@ sv/pil_pkg.sv @@
// ----------------------------------------------------------------------------
// pil_pkg
// shared types and constants for the positional insert list
// ----------------------------------------------------------------------------
package pil_pkg;

   localparam int POS_W         = 6;
   localparam int VAL_W         = 32;
   localparam int DEPTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      ST_LISTED  = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FWD,
      S_BWD
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_ROT_FWD,
      OP_ROT_BWD
   } cell_op_type;

   typedef struct packed {
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      status_type              status;
      logic signed [VAL_W-1:0] entry_value;
      logic                    direction;
      logic                    last;
   } rsp_payload_type;

   typedef struct packed {
      cell_op_type             op;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } cell_ctrl_type;

endpackage

@@ sv/pil_cell.sv @@
// ----------------------------------------------------------------------------
// pil_cell
// one list slot: holds an entry and trades it with its neighbours
// ----------------------------------------------------------------------------
module pil_cell import pil_pkg::*; #(
   parameter int IDX   = 0,
   parameter int LEN_W = 6
) (
   input  logic                    clock,
   input  cell_ctrl_type           ctrl,
   input  logic [LEN_W-1:0]        length,
   input  logic signed [VAL_W-1:0] prev_value,
   input  logic signed [VAL_W-1:0] next_value,
   input  logic signed [VAL_W-1:0] head_value,
   input  logic signed [VAL_W-1:0] tail_value,
   output logic signed [VAL_W-1:0] value,
   output logic signed [VAL_W-1:0] tail_term
);

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;
   logic                    is_tail;

   assign is_tail = (length == LEN_W'(IDX + 1));

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (POS_W'(IDX) == ctrl.position) begin
               value_in = ctrl.value;
            end else if (POS_W'(IDX) > ctrl.position) begin
               value_in = prev_value;
            end
         end
         OP_ROT_FWD: begin
            value_in = is_tail ? head_value : next_value;
         end
         OP_ROT_BWD: begin
            value_in = (IDX == 0) ? tail_value : prev_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign tail_term = is_tail ? value_ff : '0;

endmodule

@@ sv/positional_insert_list_top.sv @@
// ----------------------------------------------------------------------------
// positional_insert_list_top
// ordered list of signed values with insert at a position and full listing
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   req_     | in        | req_valid/req_ready  | position, value
//   rsp_     | out       | rsp_valid/rsp_ready  | status, entry_value, direction,
//            |           |                      | last
//
// a good insert is taken, then the list of length L goes out as 2*L
// transactions, one per cycle while rsp_ready is high, as the row of cells
// rotates one place per result
// a bad position or a full list gives one transaction and no list change
// reset clears the length and the control; the cells themselves are not reset
// a stalled rsp_ready freezes the rotation and holds the result register
//
module positional_insert_list_top import pil_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // length must reach DEPTH itself, counter only up to DEPTH-1
   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type       state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            slot_free;
   logic            req_fire;
   logic            pos_bad;
   logic            is_full;
   logic            cnt_end;
   logic            good_insert;
   logic            rsp_load;
   rsp_payload_type rsp_next;
   cell_ctrl_type   cell_ctrl;

   logic signed [VAL_W-1:0] cell_value [DEPTH];
   logic signed [VAL_W-1:0] cell_tail  [DEPTH];
   logic signed [VAL_W-1:0] tail_value;

   // result register is free when empty or being taken this cycle
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign pos_bad     = req_payload.position > POS_W'(len_ff);
   assign is_full     = (len_ff == LEN_W'(DEPTH));
   assign cnt_end     = (LEN_W'(cnt_ff) == (len_ff - LEN_W'(1)));
   assign good_insert = req_fire && !pos_bad && !is_full;

   // tail entry picked out by the cell that knows it is last
   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_value = tail_value | cell_tail[i];
      end
   end

   // row of cells: insert shifts the back part one place back, rotation
   // brings the next entry to the head (forward) or the tail (backward)
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VAL_W-1:0] prev_value;
      logic signed [VAL_W-1:0] next_value;

      if (g == 0) begin : g_first
         assign prev_value = '0;
      end else begin : g_mid_prev
         assign prev_value = cell_value[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign next_value = '0;
      end else begin : g_mid_next
         assign next_value = cell_value[g+1];
      end

      pil_cell #(
         .IDX   (g),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .length     (len_ff),
         .prev_value (prev_value),
         .next_value (next_value),
         .head_value (cell_value[0]),
         .tail_value (tail_value),
         .value      (cell_value[g]),
         .tail_term  (cell_tail[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (good_insert) begin
               state_in = S_FWD;
            end
         end
         S_FWD: begin
            if (slot_free && cnt_end) begin
               state_in = S_BWD;
            end
         end
         S_BWD: begin
            if (slot_free && cnt_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready          = 1'b0;
      rsp_load           = 1'b0;
      rsp_next           = '0;
      cell_ctrl.op       = OP_HOLD;
      cell_ctrl.position = req_payload.position;
      cell_ctrl.value    = req_payload.value;
      case (state_ff)
         S_IDLE: begin
            req_ready = slot_free;
            if (req_fire) begin
               if (pos_bad) begin
                  // position check comes before the full check
                  rsp_load        = 1'b1;
                  rsp_next.status = ST_INVALID;
                  rsp_next.last   = 1'b1;
               end else if (is_full) begin
                  rsp_load        = 1'b1;
                  rsp_next.status = ST_FULL;
                  rsp_next.last   = 1'b1;
               end else begin
                  cell_ctrl.op = OP_INSERT;
               end
            end
         end
         S_FWD: begin
            if (slot_free) begin
               rsp_load             = 1'b1;
               rsp_next.status      = ST_LISTED;
               rsp_next.entry_value = cell_value[0];
               rsp_next.direction   = 1'b0;
               rsp_next.last        = 1'b0;
               cell_ctrl.op         = OP_ROT_FWD;
            end
         end
         S_BWD: begin
            if (slot_free) begin
               rsp_load             = 1'b1;
               rsp_next.status      = ST_LISTED;
               rsp_next.entry_value = tail_value;
               rsp_next.direction   = 1'b1;
               rsp_next.last        = cnt_end;
               cell_ctrl.op         = OP_ROT_BWD;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // pass counter and list length
   always_comb begin
      cnt_in = cnt_ff;
      len_in = len_ff;
      if ((state_ff == S_FWD || state_ff == S_BWD) && slot_free) begin
         cnt_in = cnt_end ? '0 : cnt_ff + CNT_W'(1);
      end
      if (good_insert) begin
         len_in = len_ff + LEN_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   // the list never holds more than DEPTH entries
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(DEPTH))
      else $error("list length beyond depth");

   // a good insert grows the list by exactly one entry
   a_len_grow: assert property (@(posedge clock) disable iff (reset)
      good_insert |=> (len_ff == $past(len_ff) + LEN_W'(1)))
      else $error("insert did not grow list by one");

   // an error transaction is always the final one
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_LISTED) |-> rsp_payload.last)
      else $error("error transaction not marked last");

   // the final listed transaction returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BWD && slot_free && cnt_end) |=> (state_ff == S_IDLE))
      else $error("no return to idle after final transaction");
`endif

endmodule

@@ test/positional_insert_list_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_insert_list_checker
// watches both channels, keeps its own copy of the list and checks listings
// ----------------------------------------------------------------------------
module positional_insert_list_checker import pil_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              failures,
   output int              awaited,
   output int              inserts_seen,
   output int              listed_seen,
   output int              invalid_seen,
   output int              full_seen
);

   localparam int REPORT_LIMIT = 10;

   logic signed [VAL_W-1:0] list_vals [DEPTH];
   int unsigned             list_len;
   rsp_payload_type         awaited_listing [$];

   // apply one insert to the local list and queue the transactions it causes
   task automatic insert_and_list(input req_payload_type t);
      rsp_payload_type r;
      int unsigned     total;
      r = '0;
      r.last = 1'b1;
      if (t.position > list_len) begin
         // position check comes first, even on a full list
         r.status = ST_INVALID;
         awaited_listing.push_back(r);
      end else if (list_len >= DEPTH) begin
         r.status = ST_FULL;
         awaited_listing.push_back(r);
      end else begin
         for (int i = list_len; i > t.position; i--)
            list_vals[i] = list_vals[i-1];
         list_vals[t.position] = t.value;
         list_len++;
         inserts_seen <= inserts_seen + 1;
         total = 2 * list_len;
         for (int k = 0; k < total; k++) begin
            r.status      = ST_LISTED;
            r.direction   = (k >= list_len);
            r.entry_value = (k < list_len) ? list_vals[k] : list_vals[total-1-k];
            r.last        = (k == total - 1);
            awaited_listing.push_back(r);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         list_len = 0;
         awaited_listing.delete();
         failures     <= 0;
         inserts_seen <= 0;
         listed_seen  <= 0;
         invalid_seen <= 0;
         full_seen    <= 0;
      end else begin
         // result side first: a transaction never answers an insert of the same edge
         if (rsp_valid && rsp_ready) begin
            if (awaited_listing.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("%0t unexpected result: status %0d value %0d dir %0b last %0b",
                           $realtime, rsp_payload.status, rsp_payload.entry_value,
                           rsp_payload.direction, rsp_payload.last);
               failures <= failures + 1;
            end else begin
               want = awaited_listing.pop_front();
               if (rsp_payload.status !== want.status ||
                   rsp_payload.entry_value !== want.entry_value ||
                   rsp_payload.direction !== want.direction ||
                   rsp_payload.last !== want.last) begin
                  if (failures < REPORT_LIMIT)
                     $display("%0t mismatch: want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                              $realtime, want.status, want.entry_value, want.direction,
                              want.last, rsp_payload.status, rsp_payload.entry_value,
                              rsp_payload.direction, rsp_payload.last);
                  failures <= failures + 1;
               end
               case (want.status)
                  ST_LISTED:  listed_seen  <= listed_seen + 1;
                  ST_INVALID: invalid_seen <= invalid_seen + 1;
                  default:    full_seen    <= full_seen + 1;
               endcase
            end
         end
         if (req_valid && req_ready)
            insert_and_list(req_payload);
      end
      awaited <= awaited_listing.size();
   end

endmodule

@@ test/positional_insert_list_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_insert_list_top_test
// drives inserts into the positional insert list and judges the listings
// ----------------------------------------------------------------------------
// a short directed run covers bad positions on an empty list, inserts at the
// front, back and middle and the value extremes; random inserts then fill the
// list, the full-list refusals are hit head on, and random refusals follow
// the checker beside the block predicts every transaction and counts failures
// ----------------------------------------------------------------------------
module positional_insert_list_top_test import pil_pkg::*; ();

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int ITEM_COUNT     = 480;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 80;
   // longest quiet stretch: sender gap plus a stalled receiver, many times over
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PRESSURE_ITEM  = 300;

   // receiver behaviour, chosen by bits 9:8 of the free-running rx_cycle counter
   typedef enum logic [1:0] {
      RX_STEADY,
      RX_RANDOM,
      RX_PERIODIC,
      RX_LONG_STALL
   } rx_mode_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   int failures, awaited;
   int inserts_seen, listed_seen, invalid_seen, full_seen;

   // stimulus side bookkeeping
   int unsigned sent_len;
   int unsigned items_sent;
   int unsigned burst_left;

   // receiver pattern
   logic [31:0] rx_cycle = '0;
   int unsigned stall_left = 0;
   int unsigned idle_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   positional_insert_list_top #(.DEPTH(DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   positional_insert_list_checker #(.DEPTH(DEPTH)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .failures     (failures),
      .awaited      (awaited),
      .inserts_seen (inserts_seen),
      .listed_seen  (listed_seen),
      .invalid_seen (invalid_seen),
      .full_seen    (full_seen)
   );

   // offer one insert transaction and hold it until the block takes it
   // bursts end in a gap; apart from drain_listings, that is the only place valid drops
   task automatic offer_insert(input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val);
      req_payload_type p;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
      end
      burst_left--;
      p.position = pos;
      p.value    = val;
      req_payload <= p;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      // shadow length, only used to shape the stimulus
      if (pos <= sent_len && sent_len < DEPTH)
         sent_len++;
   endtask

   // hold the sender off until every listing has been drained
   task automatic drain_listings;
      req_valid <= 1'b0;
      // awaited is a registered copy of the checker's queue size
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   // mostly good positions while there is room, with front and back favoured
   function automatic logic [POS_W-1:0] pick_position;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (sent_len < DEPTH) begin
         if (roll < 15)      return POS_W'(0);
         else if (roll < 30) return POS_W'(sent_len);
         else if (roll < 85) return POS_W'($urandom_range(0, sent_len));
         else                return POS_W'($urandom_range(sent_len + 1, 63));
      end
      // list is full: refusals either way, split between full and bad position
      if (roll < 50) return POS_W'($urandom_range(0, DEPTH));
      return POS_W'($urandom_range(DEPTH + 1, 63));
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value;
      case ($urandom_range(0, 19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // receiver: a pattern of its own, independent of the sender
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         case (rx_mode_type'(rx_cycle[9:8]))
            RX_STEADY:   rsp_ready <= 1'b1;
            RX_RANDOM:   rsp_ready <= ($urandom_range(0, 99) < 70);
            RX_PERIODIC: rsp_ready <= (rx_cycle % 3 != 0);
            default: begin
               if ($urandom_range(0, 99) < 15) begin
                  rsp_ready  <= 1'b0;
                  stall_left <= $urandom_range(1, 7);
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // watchdog: too long with no transaction on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results still due",
                     idle_cycles, awaited);
            $display("FAIL positional_insert_list_top");
            $finish;
         end
      end
   end

   initial begin
      sent_len   = 0;
      items_sent = 0;
      burst_left = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: bad positions on an empty list
      offer_insert(6'd1, 32'sd5);
      offer_insert(6'd63, 32'sh1234_5678);
      // first entry, then back, front and middle inserts with extreme values
      offer_insert(6'd0, 32'sh8000_0000);
      offer_insert(6'd1, 32'sh7fff_ffff);
      offer_insert(6'd0, '0);
      offer_insert(6'd1, -32'sd1);
      offer_insert(6'd4, 32'sh5555_5555);
      // one past the end is already out of range
      offer_insert(6'd6, 32'sd7);
      offer_insert(6'd2, 32'shaaaa_aaaa);
      // positions well beyond the length while room remains
      offer_insert(6'd32, 32'sd9);
      offer_insert(6'd42, pick_value());
      offer_insert(6'd21, pick_value());
      drain_listings();

      while (items_sent < ITEM_COUNT) begin
         offer_insert(pick_position(), pick_value());
         if (sent_len == DEPTH && items_sent < ITEM_COUNT && full_seen == 0 &&
             invalid_seen < 1000) begin
            // list just filled: let it settle, then poke the full-list cases directly
            if (awaited >= 0) drain_listings();
            offer_insert(6'd32, pick_value());  // at the end of a full list
            offer_insert(6'd33, pick_value());  // beyond the end, checked first
            offer_insert(6'd0, pick_value());   // at the front of a full list
            offer_insert(6'd63, pick_value());
            drain_listings();
         end
         if (items_sent == PRESSURE_ITEM)
            drain_listings();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d good inserts, %0d listed entries checked",
               items_sent, inserts_seen, listed_seen);
      $display("%0d bad-position and %0d full-list refusals checked, %0d failures",
               invalid_seen, full_seen, failures);
      if (failures == 0 && awaited == 0) begin
         $display("PASS positional_insert_list_top");
      end else begin
         $display("FAIL positional_insert_list_top");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/pil_pkg.sv
sv/pil_cell.sv
sv/positional_insert_list_top.sv
test/positional_insert_list_checker.sv
test/positional_insert_list_top_test.sv
